### rtl/gap_buffer_text_editor_assert.svh
// Assertion macros shared by the RTL. Each checks on the rising clock edge
// and is switched off while reset is high.
`ifndef GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH
`define GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH

// A condition that must hold at every edge.
`define GBTE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define GBTE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/gbte_pkg.sv
package gbte_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int PTR_W    = ADDR_W + 1;

  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 13;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 13;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
  localparam logic [OP_W-1:0] OP_LEFT      = 3'd2;
  localparam logic [OP_W-1:0] OP_RIGHT     = 3'd3;
  localparam logic [OP_W-1:0] OP_SCAN_BACK = 3'd4;
  localparam logic [OP_W-1:0] OP_SCAN_FWD  = 3'd5;
  localparam logic [OP_W-1:0] OP_LINE_UP   = 3'd6;
  localparam logic [OP_W-1:0] OP_LINE_DOWN = 3'd7;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDARY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

endpackage

### rtl/gbte_ram.sv
module gbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gap_buffer_text_editor.sv
// Channel | Dir | Handshake            | Fields
// in      | in  | in_valid / in_ready   | operation, char_in, column
// out     | out | out_valid / out_ready | status, char_out, distance
//
// A command goes from idle to the result register, with a read and then a check
// and write back for each byte it reads from the store, plus a further read step
// where it stops at a text boundary.
// Reset clears the cursor, the gap, the sequencer and the result valid flag;
// the text store is not cleared. in_ready is high only while no command is at
// work; a full result register holds the next result until out_ready frees it.
`include "gap_buffer_text_editor_assert.svh"

module gap_buffer_text_editor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gbte_pkg::OP_W-1:0]      operation,
  input  logic [gbte_pkg::CHAR_W-1:0]    char_in,
  input  logic [gbte_pkg::COL_W-1:0]     column,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gbte_pkg::STATUS_W-1:0]  status,
  output logic [gbte_pkg::CHAR_W-1:0]    char_out,
  output logic [gbte_pkg::DIST_W-1:0]    distance
);
  import gbte_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RD     = 2'd1;  // issue store read, check bounds
  localparam logic [1:0] S_CHK    = 2'd2;  // read data back: test, move byte
  localparam logic [1:0] S_RESULT = 2'd3;  // hand result to output register

  // Phases of a command
  localparam logic [3:0] P_DEL    = 4'd0;  // delete byte before cursor
  localparam logic [3:0] P_LEFT1  = 4'd1;  // one step left
  localparam logic [3:0] P_RIGHT1 = 4'd2;  // one step right
  localparam logic [3:0] P_SCANB  = 4'd3;  // count back to newline
  localparam logic [3:0] P_SCANF  = 4'd4;  // count forward to newline
  localparam logic [3:0] P_UPA    = 4'd5;  // walk left to line start, cross newline
  localparam logic [3:0] P_UPC    = 4'd6;  // walk left to previous line start
  localparam logic [3:0] P_DNA    = 4'd7;  // walk right to line end, cross newline
  localparam logic [3:0] P_COL    = 4'd8;  // walk right up to column

  logic [1:0]          state, state_next;
  logic [3:0]          phase, phase_next;
  ptr_t                gs, gs_next;      // gap start = cursor
  ptr_t                ge, ge_next;      // gap end
  ptr_t                cnt, cnt_next;    // scan distance or bytes walked
  logic [COL_W-1:0]    col;

  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [CHAR_W-1:0]   res_char, res_char_next;
  logic [DIST_W-1:0]   res_dist, res_dist_next;

  // Text store port
  logic                we;
  addr_t               waddr;
  logic [CHAR_W-1:0]   wdata;
  addr_t               raddr;
  logic [CHAR_W-1:0]   rdata;

  logic                accept;
  logic                out_free;
  logic                is_left;
  logic                is_scan;
  ptr_t                offs;
  ptr_t                back_pos;
  ptr_t                fwd_pos;
  ptr_t                back_m1;
  ptr_t                ge_m1;
  logic                at_edge;
  logic                col_hit;
  logic                is_nl;
  logic                mv_left;
  logic                mv_right;

  ptr_t                gap_len;
  logic                ins_ok;
  logic                chk_move;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Address and boundary of the byte the current phase looks at
  assign is_left  = (phase == P_DEL) || (phase == P_LEFT1) || (phase == P_SCANB) ||
                    (phase == P_UPA) || (phase == P_UPC);
  assign is_scan  = (phase == P_SCANB) || (phase == P_SCANF);
  assign offs     = is_scan ? cnt : '0;
  assign back_pos = gs - offs;
  assign fwd_pos  = ge + offs;
  assign back_m1  = back_pos - PTR_W'(1);
  assign ge_m1    = ge - PTR_W'(1);
  assign at_edge  = is_left ? (back_pos == '0) : (fwd_pos == PTR_W'(CAPACITY));
  assign raddr    = is_left ? back_m1[ADDR_W-1:0] : fwd_pos[ADDR_W-1:0];
  assign col_hit  = ({{COL_W{1'b0}}, cnt} == {{PTR_W{1'b0}}, col});
  assign is_nl    = (rdata == NEWLINE);

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    gs_next         = gs;
    ge_next         = ge;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_char_next   = res_char;
    res_dist_next   = res_dist;
    we              = 1'b0;
    waddr           = gs[ADDR_W-1:0];
    wdata           = char_in;
    mv_left         = 1'b0;
    mv_right        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_DONE;
          res_char_next   = '0;
          res_dist_next   = '0;
          cnt_next        = '0;
          state_next      = S_RD;
          unique case (operation)
            OP_INSERT: begin
              // keep one gap cell free: refuse when only one remains
              if ((ge - gs) <= PTR_W'(1)) begin
                res_status_next = ST_FULL;
              end else begin
                we      = 1'b1;
                gs_next = gs + PTR_W'(1);
              end
              state_next = S_RESULT;
            end
            OP_DELETE:    phase_next = P_DEL;
            OP_LEFT:      phase_next = P_LEFT1;
            OP_RIGHT:     phase_next = P_RIGHT1;
            OP_SCAN_BACK: phase_next = P_SCANB;
            OP_SCAN_FWD:  phase_next = P_SCANF;
            OP_LINE_UP:   phase_next = P_UPA;
            OP_LINE_DOWN: phase_next = P_DNA;
          endcase
        end
      end

      S_RD: begin
        if (at_edge) begin
          // hit text start or text end
          state_next = S_RESULT;
          unique case (phase)
            P_SCANB, P_SCANF: res_dist_next = DIST_W'(cnt);
            P_UPC: begin
              // previous line starts at text start: now go to the column
              phase_next = P_COL;
              cnt_next   = '0;
              state_next = S_RD;
            end
            P_COL: ;
            default: res_status_next = ST_BOUNDARY;
          endcase
        end else if ((phase == P_COL) && col_hit) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_CHK;
        end
      end

      S_CHK: begin
        state_next = S_RD;
        unique case (phase)
          P_DEL: begin
            gs_next       = gs - PTR_W'(1);
            res_char_next = rdata;
            state_next    = S_RESULT;
          end
          P_LEFT1: begin
            mv_left       = 1'b1;
            res_char_next = rdata;
            state_next    = S_RESULT;
          end
          P_RIGHT1: begin
            mv_right      = 1'b1;
            res_char_next = rdata;
            state_next    = S_RESULT;
          end
          P_SCANB, P_SCANF: begin
            if (is_nl) begin
              res_dist_next = DIST_W'(cnt);
              state_next    = S_RESULT;
            end else begin
              cnt_next = cnt + PTR_W'(1);
            end
          end
          P_UPA: begin
            // the newline itself is crossed too, then the previous line
            mv_left = 1'b1;
            if (is_nl) begin
              phase_next = P_UPC;
            end
          end
          P_UPC: begin
            if (is_nl) begin
              phase_next = P_COL;
              cnt_next   = '0;
            end else begin
              mv_left = 1'b1;
            end
          end
          P_DNA: begin
            mv_right = 1'b1;
            if (is_nl) begin
              phase_next = P_COL;
              cnt_next   = '0;
            end
          end
          P_COL: begin
            if (is_nl) begin
              state_next = S_RESULT;
            end else begin
              mv_right = 1'b1;
              cnt_next = cnt + PTR_W'(1);
            end
          end
          default: state_next = S_RESULT;
        endcase
      end

      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase

    // Move one byte across the gap, copying it to the other side
    if (mv_left) begin
      we      = 1'b1;
      waddr   = ge_m1[ADDR_W-1:0];
      wdata   = rdata;
      gs_next = gs - PTR_W'(1);
      ge_next = ge_m1;
    end else if (mv_right) begin
      we      = 1'b1;
      waddr   = gs[ADDR_W-1:0];
      wdata   = rdata;
      gs_next = gs + PTR_W'(1);
      ge_next = ge + PTR_W'(1);
    end
  end

  gbte_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CAPACITY)
  ) u_text (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_DEL;
      gs        <= '0;
      ge        <= PTR_W'(CAPACITY);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      gs    <= gs_next;
      ge    <= ge_next;
      if ((state == S_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the column, count and result of the command at work
  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_char   <= res_char_next;
    res_dist   <= res_dist_next;
    if (accept) begin
      col <= column;
    end
    if ((state == S_RESULT) && out_free) begin
      status   <= res_status;
      char_out <= res_char;
      distance <= res_dist;
    end
  end

  assign gap_len  = ge - gs;
  assign ins_ok   = accept && (operation == OP_INSERT) && (gap_len > PTR_W'(1));
  assign chk_move = (state == S_CHK) && (phase != P_DEL);

  `GBTE_CHECK(a_gap_order, (gs < ge) && (ge <= PTR_W'(CAPACITY)), "gap bounds out of order")

  `GBTE_CHECK_NEXT(a_insert_step, ins_ok, gs == PTR_W'($past(gs) + PTR_W'(1)), "insert stuck")

  `GBTE_CHECK_NEXT(a_move_keeps_gap, chk_move, gap_len == $past(gap_len), "move changed gap")

  `GBTE_CHECK(a_result_source, $rose(out_valid) |-> ($past(state) == S_RESULT), "stray result")

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import gbte_pkg::*;

  // Timeout. Line moves walk at most the text, which the tests keep to a few
  // hundred bytes, and idling on both sides adds to each transaction.
  // The slowest legal run stays well under this.
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   char_out;
    logic [DIST_W-1:0]   distance;
  } edit_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     operation = OP_INSERT;
  logic [CHAR_W-1:0]   char_in = '0;
  logic [COL_W-1:0]    column = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [CHAR_W-1:0]   char_out;
  logic [DIST_W-1:0]   distance;

  gap_buffer_text_editor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .char_in   (char_in),
    .column    (column),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .char_out  (char_out),
    .distance  (distance)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the editor: text below the cursor sits in
  // text_mem[0 .. cursor-1], text after it in text_mem[tail_start ..].
  // ---------------------------------------------------------------------
  logic [CHAR_W-1:0] text_mem [CAPACITY];
  int unsigned       cursor;
  int unsigned       tail_start;

  edit_reply_t pending_replies[$];
  int          fault_count = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;   // set for stretches with no idling
  int          rx_hold = 0;      // one-shot long stall for the receiver

  function automatic int unsigned text_length();
    return cursor + CAPACITY - tail_start;
  endfunction

  // Move one byte from before the cursor to after it; return that byte.
  function automatic logic [CHAR_W-1:0] shift_left();
    if (cursor == 0 || tail_start == 0) return '0;
    cursor--;
    tail_start--;
    text_mem[tail_start] = text_mem[cursor];
    return text_mem[tail_start];
  endfunction

  // Move one byte from after the cursor to before it; return that byte.
  function automatic logic [CHAR_W-1:0] shift_right();
    logic [CHAR_W-1:0] b;
    if (tail_start >= CAPACITY) return '0;
    b = text_mem[tail_start];
    text_mem[cursor] = b;
    cursor++;
    tail_start++;
    return b;
  endfunction

  // Bytes from the cursor back to the previous newline, or to text start.
  function automatic int unsigned bytes_to_line_start();
    int unsigned p = cursor;
    int unsigned d = 0;
    while (p > 0) begin
      p--;
      if (text_mem[p] == NEWLINE) break;
      d++;
    end
    return d;
  endfunction

  // Bytes from the cursor forward to the next newline, or to text end.
  function automatic int unsigned bytes_to_line_end();
    int unsigned p = tail_start;
    int unsigned d = 0;
    while (p < CAPACITY) begin
      if (text_mem[p] == NEWLINE) break;
      d++;
      p++;
    end
    return d;
  endfunction

  function automatic void walk_back(int unsigned n);
    repeat (n) void'(shift_left());
  endfunction

  function automatic void walk_ahead(int unsigned n);
    repeat (n) void'(shift_right());
  endfunction

  // Apply one editing command to the shadow copy and return its reply.
  function automatic edit_reply_t predict_edit(logic [OP_W-1:0] op,
                                               logic [CHAR_W-1:0] ch,
                                               logic [COL_W-1:0] col);
    edit_reply_t r;
    int unsigned len;
    r = '{status: ST_DONE, char_out: '0, distance: '0};
    case (op)
      OP_INSERT: begin
        // One gap cell always stays free.
        if (tail_start - cursor <= 1) begin
          r.status = ST_FULL;
        end else begin
          text_mem[cursor] = ch;
          cursor++;
        end
      end
      OP_DELETE: begin
        if (cursor == 0) begin
          r.status = ST_BOUNDARY;
        end else begin
          cursor--;
          r.char_out = text_mem[cursor];
        end
      end
      OP_LEFT: begin
        if (cursor == 0) r.status = ST_BOUNDARY;
        else r.char_out = shift_left();
      end
      OP_RIGHT: begin
        if (tail_start >= CAPACITY) r.status = ST_BOUNDARY;
        else r.char_out = shift_right();
      end
      OP_SCAN_BACK: r.distance = DIST_W'(bytes_to_line_start());
      OP_SCAN_FWD:  r.distance = DIST_W'(bytes_to_line_end());
      OP_LINE_UP: begin
        if (cursor == 0) begin
          r.status = ST_BOUNDARY;
        end else begin
          walk_back(bytes_to_line_start());
          // Already on the first line: stop at text start.
          if (cursor == 0) begin
            r.status = ST_BOUNDARY;
          end else begin
            void'(shift_left());
            walk_back(bytes_to_line_start());
            len = bytes_to_line_end();
            walk_ahead((col < len) ? col : len);
          end
        end
      end
      default: begin
        if (tail_start >= CAPACITY) begin
          r.status = ST_BOUNDARY;
        end else begin
          walk_ahead(bytes_to_line_end());
          // Already on the last line: stop at text end.
          if (tail_start >= CAPACITY) begin
            r.status = ST_BOUNDARY;
          end else begin
            void'(shift_right());
            len = bytes_to_line_end();
            walk_ahead((col < len) ? col : len);
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(string msg);
    fault_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------
  // Sender. Each call starts on the falling edge after the previous
  // transaction, so valid is either lowered or given the next payload in
  // that step, never both. The expected reply is queued at acceptance.
  // ---------------------------------------------------------------------
  task automatic send_edit(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [COL_W-1:0] col);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    char_in   <= ch;
    column    <= col;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_replies.push_back(predict_edit(op, ch, col));
  endtask

  // Drop valid, then hold until every queued reply has come back.
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver and checker: draw a stall per reply, then take the next
  // transaction and compare it against the oldest expectation.
  // ---------------------------------------------------------------------
  initial begin
    int          stall;
    edit_reply_t want;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected reply status=%0d char=%02h dist=%0d",
                                  status, char_out, distance));
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (char_out !== want.char_out)
          report_mismatch($sformatf("char_out %02h, expected %02h",
                                    char_out, want.char_out));
        if (distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    distance, want.distance));
      end
    end
  end

  // Cycle counter: end the run if the block hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Boundaries on an empty store, then a short text with the extreme byte
  // values and three lines, walked with every line move and scan.
  task automatic test_directed();
    send_edit(OP_DELETE, 8'h00, '0);
    send_edit(OP_LEFT, 8'h00, '0);
    send_edit(OP_RIGHT, 8'h00, '0);
    send_edit(OP_SCAN_BACK, 8'h00, '0);
    send_edit(OP_SCAN_FWD, 8'h00, '0);
    send_edit(OP_LINE_UP, 8'h00, COL_W'(4096));
    send_edit(OP_LINE_DOWN, 8'h00, '0);
    send_edit(OP_INSERT, 8'h61, '0);
    send_edit(OP_INSERT, 8'h00, '0);
    send_edit(OP_INSERT, 8'hFF, '0);
    send_edit(OP_INSERT, NEWLINE, '0);
    send_edit(OP_INSERT, 8'h62, '0);
    send_edit(OP_INSERT, 8'h63, '0);
    send_edit(OP_INSERT, NEWLINE, '0);
    send_edit(OP_INSERT, 8'h64, '0);
    send_edit(OP_SCAN_BACK, 8'h00, '0);
    send_edit(OP_LINE_DOWN, 8'h00, '0);           // at text end: refused
    send_edit(OP_LEFT, 8'h00, '0);
    send_edit(OP_LINE_DOWN, 8'h00, '0);           // last line: stops at end
    send_edit(OP_LINE_UP, 8'h00, COL_W'(1));
    send_edit(OP_LINE_UP, 8'h00, COL_W'(4096));   // column past line end
    send_edit(OP_LINE_UP, 8'h00, '0);             // first line: stops at start
    send_edit(OP_SCAN_FWD, 8'h00, '0);
    send_edit(OP_LINE_DOWN, 8'h00, COL_W'(4096));
    send_edit(OP_RIGHT, 8'h00, '0);
    send_edit(OP_DELETE, 8'h00, '0);
    drain_replies();
  endtask

  // Random commands with about one newline in six inserted bytes. Insert
  // less often once the text grows long so that line moves stay cheap.
  task automatic test_random(int count);
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    int                roll;
    for (int i = 0; i < count; i++) begin
      // Run one stretch with no idling on either side.
      no_gaps = (i >= count / 2) && (i < count / 2 + 150);
      roll = $urandom_range(0, 99);
      if (roll < ((text_length() > 250) ? 12 : 38)) op = OP_INSERT;
      else op = OP_W'($urandom_range(OP_DELETE, OP_LINE_DOWN));
      ch = ($urandom_range(0, 5) == 0) ? NEWLINE : CHAR_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       col = COL_W'(4096);
        1:       col = COL_W'($urandom_range(0, 4096));
        default: col = COL_W'($urandom_range(0, 12));
      endcase
      send_edit(op, ch, col);
    end
    no_gaps = 1'b0;
    drain_replies();
  endtask

  // Stall the receiver for a long stretch while commands keep coming, so
  // the result path fills and in_ready drops; then pause until drained.
  task automatic test_backpressure();
    rx_hold = 400;
    for (int i = 0; i < 10; i++)
      send_edit(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_SCAN_BACK,
                CHAR_W'($urandom_range(0, 255)), '0);
    drain_replies();
  endtask

  // Open a new line, fill it with a long run of bytes, then run the scans
  // and line moves across it with columns inside and past its end.
  task automatic test_long_line();
    logic [CHAR_W-1:0] b;
    send_edit(OP_INSERT, NEWLINE, '0);
    for (int i = 0; i < 120; i++) begin
      b = CHAR_W'($urandom_range(0, 255));
      if (b == NEWLINE) b = 8'h0B;
      send_edit(OP_INSERT, b, '0);
    end
    send_edit(OP_SCAN_BACK, 8'h00, '0);
    send_edit(OP_SCAN_FWD, 8'h00, '0);
    send_edit(OP_LINE_UP, 8'h00, COL_W'(4096));
    send_edit(OP_LINE_DOWN, 8'h00, COL_W'(4096));
    send_edit(OP_LINE_UP, 8'h00, COL_W'(60));
    send_edit(OP_LINE_DOWN, 8'h00, '0);
    send_edit(OP_LEFT, 8'h00, '0);
    send_edit(OP_RIGHT, 8'h00, '0);
    send_edit(OP_DELETE, 8'h00, '0);
    send_edit(OP_SCAN_BACK, 8'h00, '0);
    send_edit(OP_SCAN_FWD, 8'h00, '0);
    drain_replies();
  endtask

  initial begin
    // Empty store: the gap covers everything.
    for (int i = 0; i < CAPACITY; i++) text_mem[i] = '0;
    cursor     = 0;
    tail_start = CAPACITY;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(520);
    test_backpressure();
    test_random(520);
    test_long_line();

    // Give any stray reply time to show up before the verdict.
    repeat (60) @(posedge clk);
    if (fault_count == 0 && pending_replies.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
